>>> rtl/tpc_pkg.sv
// Shared types and constants for the triangle pixel coverage test.
// Holds the request and result structs and the derived datapath widths.
// No dependencies.
package tpc_pkg;

  localparam int COORD_FRAC_BITS  = 4;
  localparam int PIXEL_COORD_BITS = 12;
  localparam int VERT_BITS        = 20;
  localparam int REG_BITS         = PIXEL_COORD_BITS + 1;

  // Pixel position scaled to vertex units, plus a sign bit.
  localparam int PIX_W   = PIXEL_COORD_BITS + COORD_FRAC_BITS + 1;
  localparam int DIFF_W  = ((VERT_BITS > PIX_W) ? VERT_BITS : PIX_W) + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int SUM_W   = CROSS_W + 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = CFG_IDX_W'(1);

  localparam logic [REG_BITS-1:0] VIEWPORT_WIDTH_RESET  = REG_BITS'(640);
  localparam logic [REG_BITS-1:0] VIEWPORT_HEIGHT_RESET = REG_BITS'(480);

  typedef struct packed {
    logic        [PIXEL_COORD_BITS-1:0] pixel_x;
    logic        [PIXEL_COORD_BITS-1:0] pixel_y;
    logic signed [VERT_BITS-1:0]        vertex_a_x;
    logic signed [VERT_BITS-1:0]        vertex_a_y;
    logic signed [VERT_BITS-1:0]        vertex_b_x;
    logic signed [VERT_BITS-1:0]        vertex_b_y;
    logic signed [VERT_BITS-1:0]        vertex_c_x;
    logic signed [VERT_BITS-1:0]        vertex_c_y;
  } tpc_req_t;

  typedef struct packed {
    logic covered;
    logic clipped;
  } tpc_rsp_t;

endpackage

>>> rtl/triangle_pixel_coverage_test.sv
// Triangle pixel coverage test, top level: a four-stage pipeline.
// Depends on tpc_pkg for the request and result types and the widths.
//
//   channel | ports                            | moves
//   input   | in_valid, in_ready, in_data      | one pixel and three vertices
//   result  | out_valid, out_ready, out_data   | covered and clipped flags
//   config  | cfg_we, cfg_index, cfg_wdata     | viewport width and height
//
// A request's result is registered through the first, second and third stages and then
// the output register, and one request can enter every cycle while no result is stalled.
// The stages are edge differences, six signed multiplies, three cross products,
// and the sum with the final compares.
// Reset restores the viewport to 640 by 480 and empties the pipeline.
// A stalled result holds the whole pipeline in place and deasserts in_ready.
module triangle_pixel_coverage_test (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tpc_pkg::tpc_req_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output tpc_pkg::tpc_rsp_t                  out_data,
  input  logic                               cfg_we,
  input  logic [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpc_pkg::REG_BITS-1:0]       cfg_wdata
);
  import tpc_pkg::*;

  logic [REG_BITS-1:0] width_r, height_r;

  logic                     advance;
  logic                     s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic                     s1_clip_r, s2_clip_r, s3_clip_r;
  logic signed [DIFF_W-1:0] s1_v0x_r, s1_v0y_r, s1_v1x_r, s1_v1y_r, s1_v2x_r, s1_v2y_r;
  logic signed [DIFF_W-1:0] s1_v0x_nxt, s1_v0y_nxt, s1_v1x_nxt, s1_v1y_nxt;
  logic signed [DIFF_W-1:0] s1_v2x_nxt, s1_v2y_nxt;
  logic signed [PIX_W-1:0]  pix_x, pix_y;
  logic                     s1_clip_nxt;
  logic signed [PROD_W-1:0] s2_pc0_r, s2_pc1_r, s2_pu0_r, s2_pu1_r, s2_pv0_r, s2_pv1_r;
  logic signed [CROSS_W-1:0] s3_c_r, s3_cu_r, s3_cv_r;
  logic signed [CROSS_W-1:0] s3_c_nxt, s3_cu_nxt, s3_cv_nxt;
  logic signed [SUM_W-1:0]  sum_uv, c_ext;
  tpc_rsp_t                 out_data_r, out_data_nxt;

  assign advance   = !out_v_r || out_ready;
  assign in_ready  = advance;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= VIEWPORT_WIDTH_RESET;
      height_r <= VIEWPORT_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VIEWPORT_WIDTH:  width_r  <= cfg_wdata;
        REG_VIEWPORT_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    pix_x = $signed(PIX_W'(in_data.pixel_x) << COORD_FRAC_BITS);
    pix_y = $signed(PIX_W'(in_data.pixel_y) << COORD_FRAC_BITS);
    s1_v0x_nxt = DIFF_W'($signed(in_data.vertex_c_x)) - DIFF_W'($signed(in_data.vertex_a_x));
    s1_v0y_nxt = DIFF_W'($signed(in_data.vertex_c_y)) - DIFF_W'($signed(in_data.vertex_a_y));
    s1_v1x_nxt = DIFF_W'($signed(in_data.vertex_b_x)) - DIFF_W'($signed(in_data.vertex_a_x));
    s1_v1y_nxt = DIFF_W'($signed(in_data.vertex_b_y)) - DIFF_W'($signed(in_data.vertex_a_y));
    s1_v2x_nxt = DIFF_W'(pix_x) - DIFF_W'($signed(in_data.vertex_a_x));
    s1_v2y_nxt = DIFF_W'(pix_y) - DIFF_W'($signed(in_data.vertex_a_y));
    s1_clip_nxt = !((REG_BITS'(in_data.pixel_x) < width_r) &&
                    (REG_BITS'(in_data.pixel_y) < height_r));
  end

  always_comb begin
    s3_c_nxt  = CROSS_W'(s2_pc0_r) - CROSS_W'(s2_pc1_r);
    s3_cu_nxt = CROSS_W'(s2_pu0_r) - CROSS_W'(s2_pu1_r);
    s3_cv_nxt = CROSS_W'(s2_pv0_r) - CROSS_W'(s2_pv1_r);
  end

  always_comb begin
    sum_uv = SUM_W'(s3_cu_r) + SUM_W'(s3_cv_r);
    c_ext  = SUM_W'(s3_c_r);
    out_data_nxt.clipped = s3_clip_r;
    out_data_nxt.covered = 1'b0;
    if (!s3_clip_r && (s3_c_r != '0)) begin
      if (!s3_c_r[CROSS_W-1]) begin
        out_data_nxt.covered = !s3_cu_r[CROSS_W-1] && !s3_cv_r[CROSS_W-1] && (sum_uv < c_ext);
      end else begin
        out_data_nxt.covered = (s3_cu_r <= 0) && (s3_cv_r <= 0) && (sum_uv > c_ext);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= in_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_v0x_r   <= s1_v0x_nxt;
      s1_v0y_r   <= s1_v0y_nxt;
      s1_v1x_r   <= s1_v1x_nxt;
      s1_v1y_r   <= s1_v1y_nxt;
      s1_v2x_r   <= s1_v2x_nxt;
      s1_v2y_r   <= s1_v2y_nxt;
      s1_clip_r  <= s1_clip_nxt;
      s2_pc0_r   <= PROD_W'(s1_v0x_r) * PROD_W'(s1_v1y_r);
      s2_pc1_r   <= PROD_W'(s1_v0y_r) * PROD_W'(s1_v1x_r);
      s2_pu0_r   <= PROD_W'(s1_v2x_r) * PROD_W'(s1_v1y_r);
      s2_pu1_r   <= PROD_W'(s1_v2y_r) * PROD_W'(s1_v1x_r);
      s2_pv0_r   <= PROD_W'(s1_v0x_r) * PROD_W'(s1_v2y_r);
      s2_pv1_r   <= PROD_W'(s1_v0y_r) * PROD_W'(s1_v2x_r);
      s2_clip_r  <= s1_clip_r;
      s3_c_r     <= s3_c_nxt;
      s3_cu_r    <= s3_cu_nxt;
      s3_cv_r    <= s3_cv_nxt;
      s3_clip_r  <= s2_clip_r;
      out_data_r <= out_data_nxt;
    end
  end

  a_cover_not_clipped: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_data_r.covered && out_data_r.clipped))
    else $error("covered and clipped are both set");

  a_degenerate_uncovered: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s3_v_r && (s3_c_r == '0)) |=> !out_data_r.covered)
    else $error("degenerate triangle reported as covered");

  a_request_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_v_r)
    else $error("accepted request did not enter the first stage");

  a_clip_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s3_v_r) |=> (out_data_r.clipped == $past(s3_clip_r)))
    else $error("clip flag lost between last stage and output");

endmodule
